@@ rtl/tdms_pkg.sv @@
package tdms_pkg;

    localparam int unsigned RUN_SECONDS_W = 8;
    localparam int unsigned SELLS_W       = 16;
    localparam int unsigned SOLD_W        = 8;
    localparam int unsigned ELAPSED_W     = 18;
    localparam int unsigned BLINK_W       = 9;
    localparam int unsigned FRAME_W       = 2;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned M_TDATA_W     = 8;

    localparam logic [ELAPSED_W-1:0] MS_PER_SECOND = ELAPSED_W'(1000);
    localparam logic [ELAPSED_W-1:0] FIRST_RUN_EXTRA_MS = ELAPSED_W'(500);
    localparam logic [ELAPSED_W-1:0] FORWARD_END_EXTRA_MS = ELAPSED_W'(3500);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [BLINK_W-1:0]   BLINK_MS = BLINK_W'(500);

    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_SECONDS       = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SELLS_PER_CYCLE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_SELLS_UNTIL_EMPTY = CFG_INDEX_W'(2);

    localparam logic [FRAME_W-1:0] FRAME_NONE   = FRAME_W'(0);
    localparam logic [FRAME_W-1:0] FRAME_ERROR  = FRAME_W'(1);
    localparam logic [FRAME_W-1:0] FRAME_RESUME = FRAME_W'(2);

endpackage

@@ rtl/timed_dispense_motor_sequencer_core.sv @@
// Each input item is one millisecond tick; the block answers every tick with
// exactly one result item holding the motor, relay, LED, acceptor-disable,
// frame request, stop-selling and fault outputs after that tick. An accepted
// item passes through an input register and its result lands in an output
// register, and a new item is taken in every cycle as long as the result
// side keeps up. All sequencer state is updated by a single pass of counters
// and compares per item.
// The user writes configuration via cfg_wr_en, cfg_index and cfg_wr_data
// only while no item is in flight; the block does not enforce this. Index
// 0 is run_seconds, 1 sells_per_cycle, 2 sells_until_empty; others ignored.
module timed_dispense_motor_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tdms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tdms_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sold[7:0], clear_empty, stock_empty, fault_set, fault_clear, zero fill.
    input  logic [tdms_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // motor_on, reverse_relay, led_on, acceptor_disable, frame_request[1:0],
    // stop_selling, fault.
    output logic [tdms_pkg::M_TDATA_W-1:0]      m_tdata
);
    import tdms_pkg::*;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_REVERSE  = 3'd1,
        PH_STOPPED  = 3'd2,
        PH_FORWARD  = 3'd3,
        PH_IDLE     = 3'd4
    } phase_t;

    logic [RUN_SECONDS_W-1:0] run_seconds_reg;
    logic [SELLS_W-1:0]       sells_per_cycle_reg;
    logic [SELLS_W-1:0]       sells_until_empty_reg;

    logic                     in_valid_reg;
    logic [S_TDATA_W-1:0]     in_data_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;

    phase_t                   phase_reg, phase_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [SELLS_W-1:0]       sale_count_reg, sale_count_next;
    logic [SELLS_W-1:0]       empty_count_reg, empty_count_next;
    logic                     stop_reg, stop_next;
    logic                     reported_reg, reported_next;
    logic                     fault_reg, fault_next;
    logic [BLINK_W-1:0]       blink_reg, blink_next;
    logic                     led_reg, led_next;
    logic                     motor_reg, motor_next;
    logic                     relay_reg, relay_next;

    logic                     advance;
    logic [SOLD_W-1:0]        sold;
    logic                     clear_empty, stock_empty, fault_set, fault_clear;
    logic [SELLS_W:0]         sale_sum, empty_sum;
    logic [SELLS_W-1:0]       empty_base;
    logic                     fault_mid;
    logic [ELAPSED_W-1:0]     run_ms, limit1, limit3;
    logic [FRAME_W-1:0]       frame;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sold        = in_data_reg[SOLD_W-1:0];
    assign clear_empty = in_data_reg[SOLD_W];
    assign stock_empty = in_data_reg[SOLD_W+1];
    assign fault_set   = in_data_reg[SOLD_W+2];
    assign fault_clear = in_data_reg[SOLD_W+3];

    assign run_ms = ELAPSED_W'(run_seconds_reg) * MS_PER_SECOND;
    assign limit1 = run_ms + FIRST_RUN_EXTRA_MS;
    assign limit3 = run_ms + FORWARD_END_EXTRA_MS;

    always_comb begin
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        sale_count_next  = sale_count_reg;
        stop_next        = stop_reg;
        blink_next       = blink_reg;
        led_next         = led_reg;
        motor_next       = motor_reg;
        relay_next       = relay_reg;
        reported_next    = reported_reg;
        frame            = FRAME_NONE;

        if (fault_set) begin
            fault_mid = 1'b1;
        end else if (fault_clear) begin
            fault_mid = 1'b0;
        end else begin
            fault_mid = fault_reg;
        end

        if (clear_empty) begin
            stop_next  = 1'b0;
            empty_base = '0;
        end else begin
            empty_base = empty_count_reg;
        end
        empty_count_next = empty_base;

        sale_sum  = {1'b0, sale_count_reg} + (SELLS_W+1)'(sold);
        empty_sum = {1'b0, empty_base} + (SELLS_W+1)'(sold);

        if (sold != '0) begin
            if (sale_sum < {1'b0, sells_per_cycle_reg}) begin
                sale_count_next = sale_sum[SELLS_W-1:0];
            end else begin
                sale_count_next = '0;
                phase_next      = PH_START;
            end
            if (empty_sum < {1'b0, sells_until_empty_reg}) begin
                empty_count_next = empty_sum[SELLS_W-1:0];
                stop_next        = 1'b0;
            end else begin
                empty_count_next = sells_until_empty_reg;
                stop_next        = 1'b1;
            end
        end

        if (blink_reg < BLINK_MS) begin
            blink_next = blink_reg + BLINK_W'(1);
        end
        if (fault_mid) begin
            if (blink_next >= BLINK_MS) begin
                led_next   = !led_reg;
                blink_next = '0;
            end
        end else begin
            led_next = 1'b1;
        end

        if (phase_next != PH_START && elapsed_reg < ELAPSED_MAX) begin
            elapsed_next = elapsed_reg + ELAPSED_W'(1);
        end
        case (phase_next)
            PH_START: begin
                relay_next   = 1'b1;
                motor_next   = 1'b1;
                elapsed_next = '0;
                phase_next   = PH_REVERSE;
            end
            PH_REVERSE: begin
                if (elapsed_next >= limit1) begin
                    motor_next = 1'b0;
                    relay_next = 1'b0;
                    phase_next = PH_STOPPED;
                end
            end
            PH_STOPPED: begin
                if (elapsed_next >= limit1) begin
                    relay_next = 1'b0;
                    motor_next = 1'b1;
                    phase_next = PH_FORWARD;
                end
            end
            PH_FORWARD: begin
                if (elapsed_next >= limit3) begin
                    motor_next = 1'b0;
                    relay_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (reported_reg != stop_next) begin
            frame         = stop_next ? FRAME_ERROR : FRAME_RESUME;
            reported_next = stop_next;
        end

        fault_next = fault_mid || (stock_empty && stop_next);

        out_data_next = {fault_next, stop_next, frame, fault_mid,
                         led_next, relay_next, motor_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_seconds_reg       <= '0;
            sells_per_cycle_reg   <= '0;
            sells_until_empty_reg <= '0;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            phase_reg             <= PH_START;
            elapsed_reg           <= '0;
            sale_count_reg        <= '0;
            empty_count_reg       <= '0;
            stop_reg              <= 1'b0;
            reported_reg          <= 1'b0;
            fault_reg             <= 1'b0;
            blink_reg             <= '0;
            led_reg               <= 1'b0;
            motor_reg             <= 1'b0;
            relay_reg             <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RUN_SECONDS:       run_seconds_reg <= cfg_wr_data[RUN_SECONDS_W-1:0];
                    CFG_SELLS_PER_CYCLE:   sells_per_cycle_reg <= cfg_wr_data[SELLS_W-1:0];
                    CFG_SELLS_UNTIL_EMPTY: sells_until_empty_reg <= cfg_wr_data[SELLS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                elapsed_reg     <= elapsed_next;
                sale_count_reg  <= sale_count_next;
                empty_count_reg <= empty_count_next;
                stop_reg        <= stop_next;
                reported_reg    <= reported_next;
                fault_reg       <= fault_next;
                blink_reg       <= blink_next;
                led_reg         <= led_next;
                motor_reg       <= motor_next;
                relay_reg       <= relay_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdms_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_INDEX_W'(3);
    localparam int unsigned WATCHDOG_CYCLES = 3000;
    localparam int unsigned LONG_STALL_CYCLES = 400;

    typedef enum logic [2:0] {
        PH_START,
        PH_REVERSE,
        PH_STOPPED,
        PH_FORWARD,
        PH_IDLE
    } seq_phase_t;

    typedef struct packed {
        logic              fault_clear;
        logic              fault_set;
        logic              stock_empty;
        logic              clear_empty;
        logic [SOLD_W-1:0] sold;
    } tick_t;

    typedef struct packed {
        logic               fault;
        logic               stop_selling;
        logic [FRAME_W-1:0] frame_request;
        logic               acceptor_disable;
        logic               led_on;
        logic               reverse_relay;
        logic               motor_on;
    } outputs_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    timed_dispense_motor_sequencer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    logic [RUN_SECONDS_W-1:0] cfg_run_s;
    logic [SELLS_W-1:0]       cfg_per_cycle;
    logic [SELLS_W-1:0]       cfg_until_empty;

    seq_phase_t           seq_phase;
    logic [ELAPSED_W-1:0] phase_ms;
    logic [16:0]          sale_cnt;
    logic [SELLS_W-1:0]   empty_cnt;
    logic                 stop_sell;
    logic                 stop_reported;
    logic                 fault_q;
    logic [BLINK_W-1:0]   blink_ms;
    logic                 led_q;
    logic                 motor_q;
    logic                 relay_q;

    outputs_t expected_outputs[$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit steady_flow = 1'b0;
    bit long_stall_request = 1'b0;

    function automatic void reset_sequencer_model();
        cfg_run_s = '0;
        cfg_per_cycle = '0;
        cfg_until_empty = '0;
        seq_phase = PH_START;
        phase_ms = '0;
        sale_cnt = '0;
        empty_cnt = '0;
        stop_sell = 1'b0;
        stop_reported = 1'b0;
        fault_q = 1'b0;
        blink_ms = '0;
        led_q = 1'b0;
        motor_q = 1'b0;
        relay_q = 1'b0;
    endfunction

    function automatic outputs_t advance_tick(input tick_t t);
        outputs_t r;
        logic [16:0] sale_sum;
        logic [16:0] empty_sum;
        logic [ELAPSED_W-1:0] stop_ms;
        logic [ELAPSED_W-1:0] forward_end_ms;
        logic [FRAME_W-1:0] frame;
        logic acceptor_off;
        frame = FRAME_NONE;
        stop_ms = ELAPSED_W'(cfg_run_s) * MS_PER_SECOND + FIRST_RUN_EXTRA_MS;
        forward_end_ms = ELAPSED_W'(cfg_run_s) * MS_PER_SECOND + FORWARD_END_EXTRA_MS;

        if (t.fault_set) begin
            fault_q = 1'b1;
        end else if (t.fault_clear) begin
            fault_q = 1'b0;
        end

        if (t.clear_empty) begin
            stop_sell = 1'b0;
            empty_cnt = '0;
        end

        if (t.sold != '0) begin
            sale_sum = sale_cnt + 17'(t.sold);
            empty_sum = 17'(empty_cnt) + 17'(t.sold);
            if (sale_sum < 17'(cfg_per_cycle)) begin
                sale_cnt = sale_sum;
            end else begin
                sale_cnt = '0;
                seq_phase = PH_START;
            end
            if (empty_sum < 17'(cfg_until_empty)) begin
                empty_cnt = empty_sum[SELLS_W-1:0];
                stop_sell = 1'b0;
            end else begin
                empty_cnt = cfg_until_empty;
                stop_sell = 1'b1;
            end
        end

        if (blink_ms < BLINK_MS) blink_ms = blink_ms + BLINK_W'(1);
        if (fault_q) begin
            if (blink_ms >= BLINK_MS) begin
                led_q = ~led_q;
                blink_ms = '0;
            end
        end else begin
            led_q = 1'b1;
        end

        if (seq_phase != PH_START && phase_ms < ELAPSED_MAX) phase_ms = phase_ms + ELAPSED_W'(1);
        case (seq_phase)
            PH_START: begin
                relay_q = 1'b1;
                motor_q = 1'b1;
                phase_ms = '0;
                seq_phase = PH_REVERSE;
            end
            PH_REVERSE: begin
                if (phase_ms >= stop_ms) begin
                    motor_q = 1'b0;
                    relay_q = 1'b0;
                    seq_phase = PH_STOPPED;
                end
            end
            PH_STOPPED: begin
                if (phase_ms >= stop_ms) begin
                    relay_q = 1'b0;
                    motor_q = 1'b1;
                    seq_phase = PH_FORWARD;
                end
            end
            PH_FORWARD: begin
                if (phase_ms >= forward_end_ms) begin
                    motor_q = 1'b0;
                    relay_q = 1'b1;
                    seq_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (stop_reported != stop_sell) begin
            frame = stop_sell ? FRAME_ERROR : FRAME_RESUME;
            stop_reported = stop_sell;
        end

        acceptor_off = fault_q;
        if (t.stock_empty && stop_sell) fault_q = 1'b1;

        r.motor_on = motor_q;
        r.reverse_relay = relay_q;
        r.led_on = led_q;
        r.acceptor_disable = acceptor_off;
        r.frame_request = frame;
        r.stop_selling = stop_sell;
        r.fault = fault_q;
        return r;
    endfunction

    function automatic tick_t mk_tick(input int unsigned sold, input int unsigned clr,
                                      input int unsigned stock, input int unsigned fset,
                                      input int unsigned fclr);
        tick_t t;
        t.sold = SOLD_W'(sold);
        t.clear_empty = 1'(clr);
        t.stock_empty = 1'(stock);
        t.fault_set = 1'(fset);
        t.fault_clear = 1'(fclr);
        return t;
    endfunction

    function automatic tick_t random_tick(input int unsigned sale_pct);
        tick_t t;
        t.sold = '0;
        if ($urandom_range(0, 99) < sale_pct) begin
            if ($urandom_range(0, 3) == 0) begin
                t.sold = SOLD_W'($urandom_range(1, 255));
            end else begin
                t.sold = SOLD_W'($urandom_range(1, 8));
            end
        end
        t.clear_empty = ($urandom_range(0, 99) < 4);
        t.stock_empty = 1'($urandom_range(0, 1));
        t.fault_set = ($urandom_range(0, 99) < 2);
        t.fault_clear = ($urandom_range(0, 99) < 3);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        while (!steady_flow && $urandom_range(0, 99) < 24) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(t);
        do @(posedge aclk); while (!s_tready);
        expected_outputs.push_back(advance_tick(t));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_RUN_SECONDS:       cfg_run_s = value[RUN_SECONDS_W-1:0];
            CFG_SELLS_PER_CYCLE:   cfg_per_cycle = value[SELLS_W-1:0];
            CFG_SELLS_UNTIL_EMPTY: cfg_until_empty = value[SELLS_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input int unsigned run_s, input int unsigned per_cycle,
                              input int unsigned until_empty);
        wait_drained();
        write_reg(CFG_RUN_SECONDS, CFG_DATA_W'(run_s));
        write_reg(CFG_SELLS_PER_CYCLE, CFG_DATA_W'(per_cycle));
        write_reg(CFG_SELLS_UNTIL_EMPTY, CFG_DATA_W'(until_empty));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_checker
        outputs_t want;
        outputs_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = outputs_t'(m_tdata);
            if (expected_outputs.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected, expected nothing, actual %h",
                         $time, got);
            end else begin
                want = expected_outputs.pop_front();
                check_field("motor_on", 32'(want.motor_on), 32'(got.motor_on));
                check_field("reverse_relay", 32'(want.reverse_relay), 32'(got.reverse_relay));
                check_field("led_on", 32'(want.led_on), 32'(got.led_on));
                check_field("acceptor_disable", 32'(want.acceptor_disable),
                            32'(got.acceptor_disable));
                check_field("frame_request", 32'(want.frame_request), 32'(got.frame_request));
                check_field("stop_selling", 32'(want.stop_selling), 32'(got.stop_selling));
                check_field("fault", 32'(want.fault), 32'(got.fault));
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        int unsigned stall_left;
        if (long_stall_request) begin
            long_stall_request = 1'b0;
            stall_left = LONG_STALL_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_zero_limits();
        send_tick(mk_tick(0, 0, 0, 0, 0));
        send_tick(mk_tick(1, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 1, 0, 0));
        send_tick(mk_tick(255, 0, 0, 0, 0));
        send_tick(mk_tick(0, 1, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 1));
        send_tick(mk_tick(0, 0, 0, 1, 1));
        send_tick(mk_tick(0, 0, 0, 0, 1));
        send_tick(mk_tick(7, 1, 1, 0, 0));
    endtask

    task automatic test_full_scale();
        set_config(255, 65535, 65535);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_tick(mk_tick(255, 0, 0, 0, 0));
        send_tick(mk_tick(255, 0, 1, 0, 0));
        send_tick(mk_tick(0, 1, 1, 1, 0));
        send_tick(mk_tick(128, 1, 0, 0, 1));
        send_tick(mk_tick(0, 0, 0, 0, 0));
    endtask

    task automatic test_lowered_limits();
        set_config(3, 1000, 1000);
        send_tick(mk_tick(200, 1, 0, 0, 0));
        send_tick(mk_tick(200, 0, 0, 0, 0));
        set_config(3, 100, 100);
        send_tick(mk_tick(1, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 1, 0, 0));
        send_tick(mk_tick(0, 1, 0, 0, 1));
    endtask

    task automatic test_motor_sequence();
        int unsigned run_s;
        run_s = 0;
        set_config(run_s, 0, 65535);
        send_tick(mk_tick(1, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_SELLS_PER_CYCLE, 16'hFFFF);
        repeat (run_s * 1000 + 600) send_tick(random_tick(0));
    endtask

    task automatic test_backpressure();
        set_config(0, 40, 60);
        steady_flow = 1'b1;
        long_stall_request = 1'b1;
        repeat (150) send_tick(random_tick(60));
        steady_flow = 1'b0;
    endtask

    task automatic test_random_settings();
        int unsigned setting;
        int unsigned n;
        for (setting = 0; setting < 5; setting++) begin
            case (setting)
                0: set_config(0, 0, 0);
                1: set_config(255, 65535, 65535);
                2, 3: set_config($urandom_range(0, 3), $urandom_range(1, 600),
                                 $urandom_range(1, 600));
                default: set_config($urandom_range(0, 255), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535));
            endcase
            for (n = 0; n < 250; n++) begin
                steady_flow = (setting == 3 && n < 200);
                send_tick(random_tick(60));
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        reset_sequencer_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_limits();
        test_full_scale();
        test_lowered_limits();
        test_motor_sequence();
        test_backpressure();
        test_random_settings();

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
